>>> rtl/tpf_pkg.sv
// tpf_pkg: widths, status codes and item types for the triangle plane fit.
// Used by every file of the block; depends on nothing.
`default_nettype none

package tpf_pkg;

    // Vertex format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RES_W       = 32;

    // Edge vectors, products and plane coefficient widths
    localparam int EDGE_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int COEF_W = PROD_W + 2;
    localparam int CLO_W  = COEF_W / 2;
    localparam int CHI_W  = COEF_W - CLO_W;
    localparam int PHI_W  = CHI_W + COORD_WIDTH;
    localparam int PLO_W  = CLO_W + 1 + COORD_WIDTH;

    // Dividend widths
    localparam int CNUM_W = COEF_W + COORD_WIDTH + 2;
    localparam int SNUM_W = COEF_W + FRAC_BITS + 1;
    localparam int NUM_W  = (CNUM_W > SNUM_W) ? CNUM_W : SNUM_W;
    localparam int UNUM_W = NUM_W + 1;
    localparam int UDEN_W = COEF_W + 1;

    // Divider: one quotient bit per stage, plus a set-up stage
    localparam int QUOT_BITS    = RES_W + 1;
    localparam int DIV_STAGES   = QUOT_BITS + 1;
    localparam int FRONT_STAGES = 6;
    localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

    typedef enum logic [2:0] {
        ST_NORMAL     = 3'd0,
        ST_COLINEAR   = 3'd1,
        ST_COINCIDENT = 3'd2,
        ST_MASKED     = 3'd3,
        ST_SATURATED  = 3'd4
    } t_fit_status;

    typedef struct packed {
        logic                          masked;
        logic signed [COORD_WIDTH-1:0] x_first;
        logic signed [COORD_WIDTH-1:0] y_first;
        logic signed [COORD_WIDTH-1:0] z_first;
        logic signed [COORD_WIDTH-1:0] x_second;
        logic signed [COORD_WIDTH-1:0] y_second;
        logic signed [COORD_WIDTH-1:0] z_second;
        logic signed [COORD_WIDTH-1:0] x_third;
        logic signed [COORD_WIDTH-1:0] y_third;
        logic signed [COORD_WIDTH-1:0] z_third;
    } t_tri_in;

    typedef struct packed {
        logic signed [RES_W-1:0] slope_x;
        logic signed [RES_W-1:0] slope_y;
        logic signed [RES_W-1:0] offset_c;
        t_fit_status             fit_status;
    } t_fit_out;

endpackage

`default_nettype wire

>>> rtl/triangle_plane_fit.sv
// triangle_plane_fit: top level, plane z = a*x + b*y + c through a triangle.
// Depends on tpf_pkg and tpf_div.
//
// One triangle is taken every clock cycle unless the output stalls; its
// result passes 6 front stages, 34 divider stages, 1 output register; the
// length is set by the three bit-per-stage dividers side by side. A stall
// on the output freezes the whole pipeline, so nothing is dropped or
// repeated. Normal triangles use the cross-product normal; colinear ones use
// the least-squares fit; masked and coincident triangles give zeros with
// their own status, and any clamped coefficient turns the status into
// saturated. No configuration and no clearing after reset.
`default_nettype none

module triangle_plane_fit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tpf_pkg::t_tri_in  i_tri,
    output logic              o_valid,
    input  logic              i_stall,
    output tpf_pkg::t_fit_out o_fit
);
    import tpf_pkg::*;

    logic adv;
    logic r_vld [1:LATENCY];

    // Stage 1: vertex 0 and edge vectors
    logic                          r1_msk;
    logic signed [COORD_WIDTH-1:0] r1_x0, r1_y0, r1_z0;
    logic signed [EDGE_W-1:0]      r1_ax, r1_ay, r1_az, r1_bx, r1_by, r1_bz;
    logic signed [EDGE_W-1:0]      n1_ax, n1_ay, n1_az, n1_bx, n1_by, n1_bz;

    // Stage 2: products
    logic                          r2_msk, r2_zxy;
    logic signed [COORD_WIDTH-1:0] r2_x0, r2_y0, r2_z0;
    logic signed [PROD_W-1:0]      r2_aybz, r2_azby, r2_azbx, r2_axbz, r2_axby, r2_aybx;
    logic signed [PROD_W-1:0]      r2_axax, r2_ayay, r2_bxbx, r2_byby;
    logic signed [PROD_W-1:0]      r2_axaz, r2_bxbz, r2_ayaz, r2_bybz;

    // Stage 3: plane terms selected by case
    logic signed [COEF_W-1:0]      n3_nx, n3_ny, n3_s, n3_na, n3_nb;
    logic                          n3_colin;
    t_fit_status                   n3_st;
    logic signed [COEF_W-1:0]      r3_p, r3_q, r3_r;
    logic signed [COORD_WIDTH-1:0] r3_x0, r3_y0, r3_z0;
    t_fit_status                   r3_st;

    // Stage 4: split products for the offset numerator
    logic signed [PHI_W-1:0]       r4_phx, r4_qhy, r4_rhz;
    logic signed [PLO_W-1:0]       r4_plx, r4_qly, r4_rlz;
    logic signed [COEF_W-1:0]      r4_p, r4_q, r4_r;
    t_fit_status                   r4_st;

    // Stage 5: whole products
    logic signed [CNUM_W-1:0]      r5_tp, r5_tq, r5_tr;
    logic signed [COEF_W-1:0]      r5_p, r5_q, r5_r;
    t_fit_status                   r5_st;

    // Stage 6: dividends and divisor
    logic signed [NUM_W-1:0]       n6_pe, n6_qe;
    logic signed [NUM_W-1:0]       r6_an, r6_bn, r6_cn;
    logic signed [COEF_W-1:0]      r6_d;
    t_fit_status                   r6_st;

    t_fit_status                   r_std [0:DIV_STAGES-1];

    logic signed [RES_W-1:0]       qa, qb, qc;
    logic                          sa, sb, sc;
    t_fit_out                      n_out, r_out;

    // Whole pipeline moves unless a finished item is held at the output
    assign adv     = !(r_vld[LATENCY] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[LATENCY];
    assign o_fit   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= LATENCY; i++) r_vld[i] <= 1'b0;
        end else if (adv) begin
            r_vld[1] <= i_valid;
            for (int i = 2; i <= LATENCY; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Stage 1
    assign n1_ax = EDGE_W'(i_tri.x_second) - EDGE_W'(i_tri.x_first);
    assign n1_ay = EDGE_W'(i_tri.y_second) - EDGE_W'(i_tri.y_first);
    assign n1_az = EDGE_W'(i_tri.z_second) - EDGE_W'(i_tri.z_first);
    assign n1_bx = EDGE_W'(i_tri.x_third)  - EDGE_W'(i_tri.x_first);
    assign n1_by = EDGE_W'(i_tri.y_third)  - EDGE_W'(i_tri.y_first);
    assign n1_bz = EDGE_W'(i_tri.z_third)  - EDGE_W'(i_tri.z_first);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_msk <= i_tri.masked;
            r1_x0  <= i_tri.x_first;
            r1_y0  <= i_tri.y_first;
            r1_z0  <= i_tri.z_first;
            r1_ax  <= n1_ax;
            r1_ay  <= n1_ay;
            r1_az  <= n1_az;
            r1_bx  <= n1_bx;
            r1_by  <= n1_by;
            r1_bz  <= n1_bz;
        end
    end

    // Stage 2: cross-product and least-squares products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_msk  <= r1_msk;
            r2_zxy  <= (r1_ax == '0) && (r1_ay == '0) && (r1_bx == '0) && (r1_by == '0);
            r2_x0   <= r1_x0;
            r2_y0   <= r1_y0;
            r2_z0   <= r1_z0;
            r2_aybz <= r1_ay * r1_bz;
            r2_azby <= r1_az * r1_by;
            r2_azbx <= r1_az * r1_bx;
            r2_axbz <= r1_ax * r1_bz;
            r2_axby <= r1_ax * r1_by;
            r2_aybx <= r1_ay * r1_bx;
            r2_axax <= r1_ax * r1_ax;
            r2_ayay <= r1_ay * r1_ay;
            r2_bxbx <= r1_bx * r1_bx;
            r2_byby <= r1_by * r1_by;
            r2_axaz <= r1_ax * r1_az;
            r2_bxbz <= r1_bx * r1_bz;
            r2_ayaz <= r1_ay * r1_az;
            r2_bybz <= r1_by * r1_bz;
        end
    end

    // Stage 3: normal or fit terms; c numerator is p*x0 + q*y0 + r*z0
    assign n3_nx    = COEF_W'(r2_aybz) - COEF_W'(r2_azby);
    assign n3_ny    = COEF_W'(r2_azbx) - COEF_W'(r2_axbz);
    assign n3_s     = COEF_W'(r2_axax) + COEF_W'(r2_ayay)
                    + COEF_W'(r2_bxbx) + COEF_W'(r2_byby);
    assign n3_na    = COEF_W'(r2_axaz) + COEF_W'(r2_bxbz);
    assign n3_nb    = COEF_W'(r2_ayaz) + COEF_W'(r2_bybz);
    assign n3_colin = (r2_axby == r2_aybx);

    always_comb begin
        if (r2_msk) begin
            n3_st = ST_MASKED;
        end else if (n3_colin && r2_zxy) begin
            n3_st = ST_COINCIDENT;
        end else if (n3_colin) begin
            n3_st = ST_COLINEAR;
        end else begin
            n3_st = ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_p  <= n3_colin ? -n3_na : n3_nx;
            r3_q  <= n3_colin ? -n3_nb : n3_ny;
            r3_r  <= n3_colin ? n3_s : (COEF_W'(r2_axby) - COEF_W'(r2_aybx));
            r3_x0 <= r2_x0;
            r3_y0 <= r2_y0;
            r3_z0 <= r2_z0;
            r3_st <= n3_st;
        end
    end

    // Stage 4: coefficient times coordinate, high and low halves
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_phx <= $signed(r3_p[COEF_W-1:CLO_W]) * r3_x0;
            r4_qhy <= $signed(r3_q[COEF_W-1:CLO_W]) * r3_y0;
            r4_rhz <= $signed(r3_r[COEF_W-1:CLO_W]) * r3_z0;
            r4_plx <= $signed({1'b0, r3_p[CLO_W-1:0]}) * r3_x0;
            r4_qly <= $signed({1'b0, r3_q[CLO_W-1:0]}) * r3_y0;
            r4_rlz <= $signed({1'b0, r3_r[CLO_W-1:0]}) * r3_z0;
            r4_p   <= r3_p;
            r4_q   <= r3_q;
            r4_r   <= r3_r;
            r4_st  <= r3_st;
        end
    end

    // Stage 5: recombine halves
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_tp <= (CNUM_W'(r4_phx) <<< CLO_W) + CNUM_W'(r4_plx);
            r5_tq <= (CNUM_W'(r4_qhy) <<< CLO_W) + CNUM_W'(r4_qly);
            r5_tr <= (CNUM_W'(r4_rhz) <<< CLO_W) + CNUM_W'(r4_rlz);
            r5_p  <= r4_p;
            r5_q  <= r4_q;
            r5_r  <= r4_r;
            r5_st <= r4_st;
        end
    end

    // Stage 6: slopes are -(p, q) scaled, offset is the sum
    assign n6_pe = NUM_W'(r5_p);
    assign n6_qe = NUM_W'(r5_q);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_an <= -(n6_pe <<< FRAC_BITS);
            r6_bn <= -(n6_qe <<< FRAC_BITS);
            r6_cn <= NUM_W'(r5_tp) + NUM_W'(r5_tq) + NUM_W'(r5_tr);
            r6_d  <= r5_r;
            r6_st <= r5_st;
        end
    end

    // Dividers, status travelling alongside
    tpf_div u_div_a (.i_clk(i_clk), .i_en(adv), .i_num(r6_an), .i_den(r6_d),
                     .o_quot(qa), .o_sat(sa));
    tpf_div u_div_b (.i_clk(i_clk), .i_en(adv), .i_num(r6_bn), .i_den(r6_d),
                     .o_quot(qb), .o_sat(sb));
    tpf_div u_div_c (.i_clk(i_clk), .i_en(adv), .i_num(r6_cn), .i_den(r6_d),
                     .o_quot(qc), .o_sat(sc));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_std[0] <= r6_st;
            for (int i = 1; i < DIV_STAGES; i++) r_std[i] <= r_std[i-1];
        end
    end

    // Output: zeros for masked and coincident items, saturation flag
    always_comb begin
        n_out = '0;
        n_out.fit_status = r_std[DIV_STAGES-1];
        if (r_std[DIV_STAGES-1] == ST_NORMAL || r_std[DIV_STAGES-1] == ST_COLINEAR) begin
            n_out.slope_x  = qa;
            n_out.slope_y  = qb;
            n_out.offset_c = qc;
            if (sa || sb || sc) begin
                n_out.fit_status = ST_SATURATED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpf_div.sv
// tpf_div: pipelined restoring divider, rounded to nearest (ties away from
// zero) with 32-bit saturation. Depends on tpf_pkg.
`default_nettype none

module tpf_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [tpf_pkg::NUM_W-1:0]  i_num,
    input  logic signed [tpf_pkg::COEF_W-1:0] i_den,
    output logic signed [tpf_pkg::RES_W-1:0]  o_quot,
    output logic                             o_sat
);
    import tpf_pkg::*;

    localparam int SH_W = UNUM_W + QUOT_BITS;

    logic [UNUM_W-1:0]    r_rem [0:QUOT_BITS];
    logic [UDEN_W-1:0]    r_den [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] r_quo [0:QUOT_BITS];
    logic                 r_neg [0:QUOT_BITS];
    logic                 r_ovf [0:QUOT_BITS];

    logic [NUM_W-1:0]     num_mag;
    logic [COEF_W-1:0]    den_mag;
    logic [QUOT_BITS-1:0] quo;
    logic                 too_big;

    // Set-up: magnitudes, rounding bias folded into the dividend
    assign num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign den_mag = i_den[COEF_W-1] ? COEF_W'(-i_den) : COEF_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {num_mag, 1'b0} + UNUM_W'(den_mag);
            r_den[0] <= {den_mag, 1'b0};
            r_quo[0] <= '0;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[COEF_W-1];
            r_ovf[0] <= 1'b0;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_step
        localparam int K = QUOT_BITS - j;
        logic [SH_W-1:0] sh_den;
        logic [SH_W-1:0] rem_ext;
        logic [SH_W-1:0] rem_dif;
        logic            ge;
        logic            big;

        assign sh_den  = SH_W'(r_den[j-1]) << K;
        assign rem_ext = SH_W'(r_rem[j-1]);
        assign ge      = rem_ext >= sh_den;
        assign rem_dif = rem_ext - sh_den;

        // quotient too wide for the bits this divider resolves
        if (j == 1) begin : g_first
            assign big = rem_ext >= (SH_W'(r_den[0]) << QUOT_BITS);
        end else begin : g_rest
            assign big = r_ovf[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? rem_dif[UNUM_W-1:0] : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_quo[j] <= r_quo[j-1] | (ge ? (QUOT_BITS'(1) << K) : '0);
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= big;
            end
        end
    end

    // Sign and clamp
    assign quo = r_quo[QUOT_BITS];

    always_comb begin
        if (r_neg[QUOT_BITS]) begin
            too_big = quo[QUOT_BITS-1] | (quo[RES_W-1] & (|quo[RES_W-2:0]));
        end else begin
            too_big = quo[QUOT_BITS-1] | quo[RES_W-1];
        end
    end

    assign o_sat = r_ovf[QUOT_BITS] | too_big;

    always_comb begin
        if (o_sat) begin
            o_quot = r_neg[QUOT_BITS] ? {1'b1, {(RES_W-1){1'b0}}}
                                      : {1'b0, {(RES_W-1){1'b1}}};
        end else if (r_neg[QUOT_BITS]) begin
            o_quot = -$signed(quo[RES_W-1:0]);
        end else begin
            o_quot = $signed(quo[RES_W-1:0]);
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpf_check.sv
// tpf_check: port-level checks for triangle_plane_fit, bound to the top.
// Depends on tpf_pkg.
`default_nettype none

module tpf_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  tpf_pkg::t_fit_out o_fit
);
    import tpf_pkg::*;

    // held result item does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_fit)))
        else $error("held result item changed");

    // input is only pushed back by a held result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // masked and coincident items give zero coefficients
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_fit.fit_status == ST_MASKED || o_fit.fit_status == ST_COINCIDENT))
        |-> (o_fit.slope_x == '0 && o_fit.slope_y == '0 && o_fit.offset_c == '0))
        else $error("nonzero coefficient on masked or coincident item");

    // saturated status means at least one clamped coefficient
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fit.fit_status == ST_SATURATED) |->
        (o_fit.slope_x == 32'sh7FFFFFFF || o_fit.slope_x == 32'sh80000000 ||
         o_fit.slope_y == 32'sh7FFFFFFF || o_fit.slope_y == 32'sh80000000 ||
         o_fit.offset_c == 32'sh7FFFFFFF || o_fit.offset_c == 32'sh80000000))
        else $error("saturated status without clamped coefficient");

endmodule

bind triangle_plane_fit tpf_check u_tpf_check (.*);

`default_nettype wire
